/* sv/tffc_pkg.sv */
// ----------------------------------------------------------------------------
// tffc_pkg - tank fill/flush controller shared types and constants
// Mode, opcode, failure and register codes, plus the config and result bundles.
// ----------------------------------------------------------------------------
package tffc_pkg;

	typedef enum logic [1:0] {
		MODE_BOOT  = 2'd0,
		MODE_IDLE  = 2'd1,
		MODE_FLUSH = 2'd2,
		MODE_FILL  = 2'd3
	} mode_t;

	typedef enum logic {
		OP_TICK     = 1'b0,
		OP_SHUTDOWN = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		FAIL_NONE     = 2'd0,
		FAIL_COOLDOWN = 2'd1,
		FAIL_DISABLED = 2'd2,
		FAIL_ALREADY  = 2'd3
	} fail_t;

	localparam int unsigned REG_IDX_BITS = 2;
	localparam logic [REG_IDX_BITS-1:0] REG_ENABLE    = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_FLUSH_DUR = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_COOLDOWN  = 2'd2;

	localparam logic [31:0] FLUSH_DUR_RESET = 32'd300000;
	localparam logic [31:0] COOLDOWN_RESET  = 32'd500000;
	localparam logic [31:0] RELAY_OFFSET_MS = 32'd5000;
	localparam logic [31:0] RETRY_MS        = 32'd60000;
	localparam logic [15:0] MIN_RUNS_FLUSH  = 16'd2;
	localparam logic [15:0] RUN_COUNT_MAX   = 16'hFFFF;

	typedef struct packed {
		logic        enabled;
		logic [31:0] flush_dur;
		logic [31:0] cooldown;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic        pump_relay;
		logic        inlet_relay;
		logic        flush_relay;
		logic        request_made;
		mode_t       requested_mode;
		logic        request_ok;
		fail_t       fail_reason;
		logic [31:0] total_pump_ms;
	} result_t;

endpackage

/* sv/tffc_if.sv */
// ----------------------------------------------------------------------------
// tffc_if - channel interfaces of the tank fill/flush controller
// Event input, result output and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface tffc_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] time_ms;
	logic        tank_full;

	modport source (output valid, opcode, time_ms, tank_full, input ready);
	modport sink   (input valid, opcode, time_ms, tank_full, output ready);
endinterface

interface tffc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic        pump_relay;
	logic        inlet_relay;
	logic        flush_relay;
	logic        request_made;
	logic [1:0]  requested_mode;
	logic        request_ok;
	logic [1:0]  fail_reason;
	logic [31:0] total_pump_ms;

	modport source (output valid, mode, pump_relay, inlet_relay, flush_relay, request_made,
		requested_mode, request_ok, fail_reason, total_pump_ms, input ready);
	modport sink   (input valid, mode, pump_relay, inlet_relay, flush_relay, request_made,
		requested_mode, request_ok, fail_reason, total_pump_ms, output ready);
endinterface

interface tffc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tffc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tffc_cfg_regs - configuration register file
// Enable flag, flush duration and pump cooldown; zero durations are dropped.
// ----------------------------------------------------------------------------
module tffc_cfg_regs
	import tffc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	tffc_cfg_if.sink     cfg,
	output cfg_t         cfg_val
);

	logic        enabled_q;
	logic [31:0] flush_dur_q;
	logic [31:0] cooldown_q;
	logic        wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= 1'b1;
			flush_dur_q <= FLUSH_DUR_RESET;
			cooldown_q  <= COOLDOWN_RESET;
		end else if (wr) begin
			case (cfg.index)
				REG_ENABLE:    enabled_q <= cfg.data[0];
				REG_FLUSH_DUR: if (cfg.data != '0) flush_dur_q <= cfg.data;
				REG_COOLDOWN:  if (cfg.data != '0) cooldown_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg_val = '{enabled: enabled_q, flush_dur: flush_dur_q, cooldown: cooldown_q};

endmodule

/* sv/tffc_core.sv */
// ----------------------------------------------------------------------------
// tffc_core - mode state and per-word decision logic
// Picks the mode request for a word, applies it to the relays and timers,
// and updates the state when the word moves on to the result register.
// ----------------------------------------------------------------------------
module tffc_core
	import tffc_pkg::*;
#(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        opcode,
	input  logic [31:0] time_ms,
	input  logic        tank_full,
	input  cfg_t        cfg_val,
	output result_t     res
);

	localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

	// state
	mode_t                mode_q, mode_d;
	logic                 pump_q, pump_d;
	logic                 inlet_q, inlet_d;
	logic                 flush_q, flush_d;
	logic                 flush_done_q, flush_done_d;
	logic                 first_q, first_d;
	logic [15:0]          runs_q, runs_d;
	logic [31:0]          total_q, total_d;
	logic [TIME_BITS-1:0] stop_t_q, stop_t_d;
	logic [TIME_BITS-1:0] start_t_q, start_t_d;
	logic [TIME_BITS-1:0] flush_t_q, flush_t_d;
	logic [TIME_BITS-1:0] attempt_q, attempt_d;

	// time arithmetic
	logic [CW-1:0]        now_w;
	logic [TIME_BITS-1:0] now, now_plus;
	logic [CW-1:0]        el_attempt, el_flush, el_stop, el_start;
	logic                 retry_due, flush_over, cool_ok;

	// request
	mode_t want;
	fail_t reason;
	logic  already;
	logic  pump_ok;

	assign now_w      = CW'(time_ms);
	assign now        = now_w[TIME_BITS-1:0];
	assign now_plus   = now + TIME_BITS'(RELAY_OFFSET_MS);
	assign el_attempt = CW'(TIME_BITS'(now - attempt_q));
	assign el_flush   = CW'(TIME_BITS'(now - flush_t_q));
	assign el_stop    = CW'(TIME_BITS'(now - stop_t_q));
	assign el_start   = CW'(TIME_BITS'(now - start_t_q));
	assign retry_due  = el_attempt >= CW'(RETRY_MS);
	assign flush_over = el_flush > CW'(cfg_val.flush_dur);
	assign cool_ok    = el_stop > CW'(cfg_val.cooldown);

	// Decide which mode, if any, this word asks for
	always_comb begin
		want         = MODE_BOOT;
		attempt_d    = attempt_q;
		flush_done_d = flush_done_q;
		if (opcode == OP_SHUTDOWN) begin
			want = MODE_IDLE;
		end else begin
			case (mode_q)
				MODE_BOOT: begin
					attempt_d = now;
					want      = MODE_IDLE;
				end
				MODE_IDLE: begin
					if (retry_due && !tank_full) begin
						want      = (flush_done_q || runs_q < MIN_RUNS_FLUSH) ?
							MODE_FILL : MODE_FLUSH;
						attempt_d = now;
					end
				end
				MODE_FLUSH: begin
					if (!cfg_val.enabled || tank_full || flush_over) begin
						flush_done_d = 1'b1;
						want         = tank_full ? MODE_IDLE : MODE_FILL;
						attempt_d    = now;
					end
				end
				MODE_FILL: begin
					if (!cfg_val.enabled || tank_full) begin
						want      = MODE_IDLE;
						attempt_d = now;
					end
				end
				default: want = MODE_BOOT;
			endcase
		end
	end

	// Apply the request: next state of mode, relays and timers
	always_comb begin
		mode_d    = mode_q;
		pump_d    = pump_q;
		inlet_d   = inlet_q;
		flush_d   = flush_q;
		first_d   = first_q;
		runs_d    = runs_q;
		total_d   = total_q;
		stop_t_d  = stop_t_q;
		start_t_d = start_t_q;
		flush_t_d = flush_t_q;
		reason    = FAIL_NONE;
		pump_ok   = 1'b0;
		if (want == MODE_IDLE) begin
			flush_d = 1'b0;
			if (pump_q) begin
				total_d  = total_q + el_start[31:0];
				stop_t_d = now;
				pump_d   = 1'b0;
				inlet_d  = 1'b0;
			end
			mode_d = MODE_IDLE;
		end else if (want != MODE_BOOT) begin
			if (!cfg_val.enabled) begin
				reason = FAIL_DISABLED;
			end else if (!pump_q) begin
				if (first_q || cool_ok) begin
					pump_ok   = 1'b1;
					inlet_d   = 1'b1;
					pump_d    = 1'b1;
					start_t_d = now_plus;
					first_d   = 1'b0;
					if (runs_q != RUN_COUNT_MAX)
						runs_d = runs_q + 16'd1;
				end else begin
					reason = FAIL_COOLDOWN;
				end
			end else if (inlet_q) begin
				pump_ok = 1'b1;
			end else begin
				reason = FAIL_COOLDOWN;
			end
			if (pump_ok) begin
				if (want == MODE_FLUSH) begin
					flush_d   = 1'b1;
					flush_t_d = pump_q ? now : now_plus;
				end
				mode_d = want;
			end
		end
		if (already)
			reason = FAIL_ALREADY;
	end

	assign already = (want != MODE_BOOT) && (want == mode_q);

	// Result word
	always_comb begin
		res.mode           = mode_d;
		res.pump_relay     = pump_d;
		res.inlet_relay    = inlet_d;
		res.flush_relay    = flush_d;
		res.request_made   = want != MODE_BOOT;
		res.requested_mode = want;
		res.request_ok     = (want != MODE_BOOT) && !already && (mode_d == want);
		res.fail_reason    = reason;
		res.total_pump_ms  = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_BOOT;
			pump_q       <= 1'b0;
			inlet_q      <= 1'b0;
			flush_q      <= 1'b0;
			flush_done_q <= 1'b0;
			first_q      <= 1'b1;
			runs_q       <= '0;
			total_q      <= '0;
			stop_t_q     <= '0;
			start_t_q    <= '0;
			flush_t_q    <= '0;
			attempt_q    <= '0;
		end else if (advance) begin
			mode_q       <= mode_d;
			pump_q       <= pump_d;
			inlet_q      <= inlet_d;
			flush_q      <= flush_d;
			flush_done_q <= flush_done_d;
			first_q      <= first_d;
			runs_q       <= runs_d;
			total_q      <= total_d;
			stop_t_q     <= stop_t_d;
			start_t_q    <= start_t_d;
			flush_t_q    <= flush_t_d;
			attempt_q    <= attempt_d;
		end
	end

	a_pump_inlet: assert property (@(posedge clk) disable iff (!arst_n)
		pump_q |-> inlet_q)
		else $error("pump running with inlet closed");

	a_active_pump: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_FLUSH || mode_q == MODE_FILL) |-> pump_q)
		else $error("fill or flush mode without pump");

	a_flush_relay: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_FLUSH) |-> flush_q)
		else $error("flush mode with flush relay off");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(flush_done_q))
		else $error("flush done flag cleared");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(total_q) && $stable(runs_q) && $stable(mode_q)))
		else $error("state changed without a word moving on");

endmodule

/* sv/tank_fill_flush_controller_unit.sv */
// ----------------------------------------------------------------------------
// tank_fill_flush_controller_unit - tank fill/flush mode controller
// Runs boot, idle, flush and fill modes from tick and shutdown events.
// ----------------------------------------------------------------------------
// Usage:
//   item   - event words: opcode (tick or shutdown), time_ms, tank_full.
//   result - one word per event: mode and relay commands after the event, the
//            mode request it made with outcome and fail reason, pump time total.
//   cfg    - register writes (enable, flush duration, pump cooldown), taken
//            whenever valid; write only with no event in flight.
// Throughput: one event per cycle while the result register is not stalled.
// Each event waits in the input register, where the decision logic evaluates
// it against the mode state; the state updates and the result word loads as
// it leaves that register, and result.valid rises as the result word loads.
// A stalled result register holds its word; one more event may wait in the
// input register behind it, after which item.ready drops until result.ready.
// Reset: boot mode, relays off, counters and timers cleared, registers at
// enabled, 300000 ms flush and 500000 ms cooldown; no clearing sweep needed.
// ----------------------------------------------------------------------------
module tank_fill_flush_controller_unit
	import tffc_pkg::*;
#(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	tffc_in_if.sink      item,
	tffc_out_if.source   result,
	tffc_cfg_if.sink     cfg
);

	cfg_t        cfg_val;
	result_t     res_d, res_q;
	logic        valid_s1;
	logic        opcode_s1;
	logic [31:0] time_s1;
	logic        full_s1;
	logic        out_valid_q;
	logic        advance;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	tffc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	tffc_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.opcode    (opcode_s1),
		.time_ms   (time_s1),
		.tank_full (full_s1),
		.cfg_val   (cfg_val),
		.res       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			opcode_s1 <= item.opcode;
			time_s1   <= item.time_ms;
			full_s1   <= item.tank_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_d;
	end

	assign result.valid          = out_valid_q;
	assign result.mode           = res_q.mode;
	assign result.pump_relay     = res_q.pump_relay;
	assign result.inlet_relay    = res_q.inlet_relay;
	assign result.flush_relay    = res_q.flush_relay;
	assign result.request_made   = res_q.request_made;
	assign result.requested_mode = res_q.requested_mode;
	assign result.request_ok     = res_q.request_ok;
	assign result.fail_reason    = res_q.fail_reason;
	assign result.total_pump_ms  = res_q.total_pump_ms;

endmodule
